>>> rtl/core/geodetic_point_projector_macros.svh
// ----------------------------------------------------------------------------
// Geodetic point projector assertion macros
// Clocked on i_clk, quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GEODETIC_POINT_PROJECTOR_MACROS_SVH
`define GEODETIC_POINT_PROJECTOR_MACROS_SVH

// same-cycle implication
`define GPP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/gpp_pkg.sv
// ----------------------------------------------------------------------------
// gpp_pkg
// Constants, types and helpers shared by the geodetic point projector.
// ----------------------------------------------------------------------------
package gpp_pkg;

    localparam int FRAME_WIDTH  = 800;
    localparam int FRAME_HEIGHT = 800;
    localparam int HALF_W       = FRAME_WIDTH / 2;
    localparam int HALF_H       = FRAME_HEIGHT / 2;
    localparam int COL_W        = $clog2(FRAME_WIDTH);
    localparam int ROW_W        = $clog2(FRAME_HEIGHT);

    // register indexes
    localparam logic [7:0] REG_ROTATION = 8'd0;
    localparam logic [7:0] REG_ZOOM     = 8'd1;
    localparam logic [31:0] ZOOM_RESET  = 32'd257698;

    // Q30 magnitudes
    localparam int MAG_W = 31;
    localparam logic [MAG_W-1:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [MAG_W-1:0] ECC2_Q30   = 31'd7188036;
    localparam logic [MAG_W-1:0] ONE_M_ECC2 = ONE_Q30 - ECC2_Q30;
    localparam logic [14:0]      QTR_TURN   = 15'd16384;

    // odd sine polynomial coefficients, Horner order after the innermost one
    localparam logic [MAG_W-1:0] K9 = 31'd172272;
    localparam logic [MAG_W-1:0] HORNER_K [4] = '{
        31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
    };

    localparam int SIN_LAT = 6;
    localparam int SQRT_N  = 31;
    localparam int DIV_N   = 24;
    localparam int TRIG_N  = 2 + SQRT_N + DIV_N;
    localparam int VLD_N   = 1 + SIN_LAT + TRIG_N;

    localparam int SQ_W  = 62;
    localparam int REM_W = 34;
    localparam int QUO_W = DIV_N;

    localparam logic [22:0] SEMI_MAJOR_M = 23'd6378137;
    localparam logic [52:0] DIV_NUM      = {SEMI_MAJOR_M, 30'b0};
    localparam logic [MAG_W-1:0] DIV_REM0 = 31'(DIV_NUM >> DIV_N);

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [MAG_W-1:0] root;
        logic [SQ_W-1:0]  v;
    } t_sqrt;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [MAG_W-1:0] root;
        logic [QUO_W-1:0] quo;
    } t_div;

    typedef struct packed {
        logic [MAG_W-1:0] sl;
        logic [MAG_W-1:0] cl;
        logic [MAG_W-1:0] sn;
        logic [MAG_W-1:0] cn;
        logic             nsl;
        logic             ncl;
        logic             nsn;
        logic             ncn;
    } t_trig;

    function automatic logic [MAG_W-1:0] horner_step(
        input logic [MAG_W-1:0] k,
        input logic [MAG_W-1:0] u,
        input logic [MAG_W-1:0] p
    );
        logic [61:0] prod;
        prod = 62'(u) * 62'(p);
        return k - prod[60:30];
    endfunction

endpackage

>>> rtl/core/gpp_sine.sv
// ----------------------------------------------------------------------------
// gpp_sine
// Six-stage sine magnitude: quadrant fold, square, four Horner steps, scale.
// ----------------------------------------------------------------------------
module gpp_sine (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [15:0]               i_ang,
    output logic [gpp_pkg::MAG_W-1:0] o_mag,
    output logic                      o_neg
);
    import gpp_pkg::*;

    logic [1:0]       w_q;
    logic [14:0]      w_r;
    logic [29:0]      w_rr;
    logic [45:0]      w_prod;
    logic [31:0]      w_s;
    logic [MAG_W-1:0] n_mag;

    logic [14:0]      r_r    [5];
    logic             r_full [5];
    logic             r_qn   [5];
    logic [MAG_W-1:0] r_u    [4];
    logic [MAG_W-1:0] r_p    [4];
    logic [MAG_W-1:0] r_mag;
    logic             r_neg;

    // fold the angle into the first quadrant
    assign w_q  = i_ang[15:14];
    assign w_r  = w_q[0] ? (QTR_TURN - {1'b0, i_ang[13:0]}) : {1'b0, i_ang[13:0]};
    assign w_rr = 30'(w_r) * 30'(w_r);

    assign w_prod = 46'(r_r[4]) * 46'(r_p[3]);
    assign w_s    = w_prod[45:14];
    assign n_mag  = (r_full[4] || w_s > 32'(ONE_Q30)) ? ONE_Q30 : w_s[MAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r[0]    <= w_r;
            r_full[0] <= (w_r == QTR_TURN);
            r_qn[0]   <= w_q[1];
            r_u[0]    <= {w_rr[28:0], 2'b00};
            r_p[0]    <= horner_step(HORNER_K[0], r_u[0], K9);
            for (int k = 1; k < 5; k++) begin
                r_r[k]    <= r_r[k-1];
                r_full[k] <= r_full[k-1];
                r_qn[k]   <= r_qn[k-1];
            end
            for (int k = 1; k < 4; k++) begin
                r_u[k] <= r_u[k-1];
                r_p[k] <= horner_step(HORNER_K[k], r_u[k], r_p[k-1]);
            end
            r_mag <= n_mag;
            r_neg <= r_qn[4] && (n_mag != '0);
        end
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg;

endmodule

>>> rtl/core/gpp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// gpp_sqrt_cell
// One root bit of a digit-by-digit square root, registered.
// ----------------------------------------------------------------------------
module gpp_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_en,
    input  gpp_pkg::t_sqrt i_st,
    output gpp_pkg::t_sqrt o_st
);
    import gpp_pkg::*;

    logic [REM_W-1:0] w_rem;
    logic [REM_W-1:0] w_trial;
    logic             w_ge;
    t_sqrt            n_st;
    t_sqrt            r_st;

    // bring down the next two radicand bits
    assign w_rem   = {i_st.rem[REM_W-3:0], i_st.v[SQ_W-1 -: 2]};
    assign w_trial = REM_W'({i_st.root, 2'b01});
    assign w_ge    = (w_rem >= w_trial);

    always_comb begin
        n_st.rem  = w_ge ? (w_rem - w_trial) : w_rem;
        n_st.root = {i_st.root[MAG_W-2:0], w_ge};
        n_st.v    = {i_st.v[SQ_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

>>> rtl/core/gpp_div_cell.sv
// ----------------------------------------------------------------------------
// gpp_div_cell
// One quotient bit of a restoring division, registered.
// ----------------------------------------------------------------------------
module gpp_div_cell (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic          i_num_bit,
    input  gpp_pkg::t_div i_st,
    output gpp_pkg::t_div o_st
);
    import gpp_pkg::*;

    logic [MAG_W:0] w_rem;
    logic           w_ge;
    logic [MAG_W:0] w_diff;
    t_div           n_st;
    t_div           r_st;

    assign w_rem  = {i_st.rem, i_num_bit};
    assign w_ge   = (w_rem >= {1'b0, i_st.root});
    assign w_diff = w_rem - {1'b0, i_st.root};

    always_comb begin
        n_st.rem  = w_ge ? w_diff[MAG_W-1:0] : w_rem[MAG_W-1:0];
        n_st.root = i_st.root;
        n_st.quo  = {i_st.quo[QUO_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

>>> rtl/core/geodetic_point_projector.sv
// Throughput: one point per cycle while the output is not stalled; the sine, root
// and divide cells all advance together.
// A stalled output holds the whole pipeline only while stage r_p4 before it holds a point.
// Dropped points (far side, off frame) give no output transfer.
// Reset clears valid flags, rotation to 0 and zoom to 257698; no memory to clear.
// ----------------------------------------------------------------------------
// geodetic_point_projector
// Geodetic angles to earth-centred metres, then to frame column, row and index.
// ----------------------------------------------------------------------------
`include "geodetic_point_projector_macros.svh"

module geodetic_point_projector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_latitude,
    input  logic [15:0] i_longitude,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [9:0]  o_pixel_col,
    output logic [9:0]  o_pixel_row,
    output logic [19:0] o_pixel_index,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import gpp_pkg::*;

    localparam int SQ_END = SIN_LAT + 2 + SQRT_N;

    logic w_en, w_out_ld, w_acc;

    logic [15:0] r_rot;
    logic [31:0] r_zoom;

    logic [VLD_N-1:0] r_vld;
    logic [15:0]      r_ang [4];
    logic [15:0]      w_lon;

    logic [MAG_W-1:0] w_mag [4];
    logic             w_neg [4];

    t_trig            r_trig [TRIG_N];
    logic [61:0]      w_s2_prod;
    logic [53:0]      w_d_prod;
    logic [MAG_W-1:0] r_s2;
    logic [MAG_W-1:0] r_d;

    t_sqrt w_sq [SQRT_N+1];
    t_div  w_dv [DIV_N+1];

    // tail stages
    logic [QUO_W-1:0] w_n;
    t_trig            w_tr;
    logic [54:0]      w_ncos_prod, w_nb_prod;
    logic             r_p1_v;
    logic [24:0]      r_p1_ncos;
    logic [24:0]      r_p1_nb;
    t_trig            r_p1_tr;

    logic [55:0]      w_mx_prod, w_my_prod, w_mz_prod;
    logic [24:0]      w_mx, w_my, w_mz;
    logic             w_negx;
    logic             r_p2_v;
    logic [24:0]      r_p2_my, r_p2_mz;
    logic             r_p2_ny, r_p2_nz;

    logic             r_p3_v;
    logic [56:0]      r_p3_sy, r_p3_sz;
    logic             r_p3_ny, r_p3_nz;

    logic signed [59:0] w_ty, w_tz;
    logic             w_okc, w_okr;
    logic             r_p4_v;
    logic [COL_W-1:0] r_p4_col;
    logic [ROW_W-1:0] r_p4_rr;

    logic [ROW_W-1:0] w_row;
    logic [31:0]      w_idx;
    logic             r_out_v;
    logic [COL_W-1:0] r_out_col;
    logic [ROW_W-1:0] r_out_row;
    logic [19:0]      r_out_idx;

    assign w_out_ld   = !r_out_v || i_out_ready;
    assign w_en       = w_out_ld || !r_p4_v;
    assign o_in_ready = w_en;
    assign w_acc      = i_in_valid && w_en;
    assign o_cfg_ready = 1'b1;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot  <= '0;
            r_zoom <= ZOOM_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_ROTATION) begin
                r_rot <= i_cfg_data[15:0];
            end else if (i_cfg_index == REG_ZOOM) begin
                r_zoom <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[VLD_N-2:0], w_acc};
        end
    end

    // angle stage: rotate longitude, form cosine angles
    assign w_lon = i_longitude + r_rot;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ang[0] <= i_latitude;
            r_ang[1] <= i_latitude + 16'(QTR_TURN);
            r_ang[2] <= w_lon;
            r_ang[3] <= w_lon + 16'(QTR_TURN);
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_sine
        gpp_sine u_sine (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_ang (r_ang[g]),
            .o_mag (w_mag[g]),
            .o_neg (w_neg[g])
        );
    end

    // sin^2 lat and 1 - e^2 sin^2 lat
    assign w_s2_prod = 62'(w_mag[0]) * 62'(w_mag[0]);
    assign w_d_prod  = 54'(ECC2_Q30) * 54'(r_s2);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2 <= w_s2_prod[60:30];
            r_d  <= ONE_Q30 - {7'b0, w_d_prod[53:30]};
            r_trig[0] <= '{sl: w_mag[0], cl: w_mag[1], sn: w_mag[2], cn: w_mag[3],
                           nsl: w_neg[0], ncl: w_neg[1], nsn: w_neg[2], ncn: w_neg[3]};
            for (int k = 1; k < TRIG_N; k++) begin
                r_trig[k] <= r_trig[k-1];
            end
        end
    end

    assign w_sq[0] = '{rem: '0, root: '0, v: {1'b0, r_d, 30'b0}};

    for (genvar g = 0; g < SQRT_N; g++) begin : g_sqrt
        gpp_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_st  (w_sq[g]),
            .o_st  (w_sq[g+1])
        );
    end

    assign w_dv[0] = '{rem: DIV_REM0, root: w_sq[SQRT_N].root, quo: '0};

    for (genvar g = 0; g < DIV_N; g++) begin : g_div
        gpp_div_cell u_cell (
            .i_clk     (i_clk),
            .i_en      (w_en),
            .i_num_bit (DIV_NUM[DIV_N-1-g]),
            .i_st      (w_dv[g]),
            .o_st      (w_dv[g+1])
        );
    end

    // N cos(lat) and N (1 - e^2)
    assign w_n         = w_dv[DIV_N].quo;
    assign w_tr        = r_trig[TRIG_N-1];
    assign w_ncos_prod = 55'(w_n) * 55'(w_tr.cl);
    assign w_nb_prod   = 55'(w_n) * 55'(ONE_M_ECC2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else if (w_en) begin
            r_p1_v <= r_vld[VLD_N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_ncos <= w_ncos_prod[54:30];
            r_p1_nb   <= w_nb_prod[54:30];
            r_p1_tr   <= w_tr;
        end
    end

    // x, y, z; drop the far side
    assign w_mx_prod = 56'(r_p1_ncos) * 56'(r_p1_tr.cn);
    assign w_my_prod = 56'(r_p1_ncos) * 56'(r_p1_tr.sn);
    assign w_mz_prod = 56'(r_p1_nb) * 56'(r_p1_tr.sl);
    assign w_mx      = w_mx_prod[54:30];
    assign w_my      = w_my_prod[54:30];
    assign w_mz      = w_mz_prod[54:30];
    assign w_negx    = (r_p1_tr.ncl != r_p1_tr.ncn) && (w_mx != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else if (w_en) begin
            r_p2_v <= r_p1_v && !w_negx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2_my <= w_my;
            r_p2_mz <= w_mz;
            r_p2_ny <= (r_p1_tr.ncl != r_p1_tr.nsn) && (w_my != '0);
            r_p2_nz <= r_p1_tr.nsl && (w_mz != '0);
        end
    end

    // zoom
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_v <= 1'b0;
        end else if (w_en) begin
            r_p3_v <= r_p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p3_sy <= 57'(r_p2_my) * 57'(r_zoom);
            r_p3_sz <= 57'(r_p2_mz) * 57'(r_zoom);
            r_p3_ny <= r_p2_ny;
            r_p3_nz <= r_p2_nz;
        end
    end

    // centre and clip
    assign w_ty  = r_p3_ny ? ((60'(HALF_W) << 32) - 60'(r_p3_sy))
                           : ((60'(HALF_W) << 32) + 60'(r_p3_sy));
    assign w_tz  = r_p3_nz ? ((60'(HALF_H) << 32) - 60'(r_p3_sz))
                           : ((60'(HALF_H) << 32) + 60'(r_p3_sz));
    assign w_okc = !w_ty[59] && (w_ty[59:32] < 28'(FRAME_WIDTH));
    assign w_okr = !w_tz[59] && (w_tz[59:32] < 28'(FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_v <= 1'b0;
        end else if (w_en) begin
            r_p4_v <= r_p3_v && w_okc && w_okr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p4_col <= w_ty[32 +: COL_W];
            r_p4_rr  <= w_tz[32 +: ROW_W];
        end
    end

    // flip row and form the index
    assign w_row = ROW_W'(FRAME_HEIGHT - 1) - r_p4_rr;
    assign w_idx = 32'(w_row) * 32'(FRAME_WIDTH) + 32'(r_p4_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_ld) begin
            r_out_v <= r_p4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ld) begin
            r_out_col <= r_p4_col;
            r_out_row <= w_row;
            r_out_idx <= w_idx[19:0];
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_pixel_col   = 10'(r_out_col);
    assign o_pixel_row   = 10'(r_out_row);
    assign o_pixel_index = r_out_idx;

    `GPP_ASSERT_NEXT(a_accept_enters, i_in_valid && o_in_ready, r_vld[0], "accepted point lost at entry")
    `GPP_ASSERT_NOW(a_hold_on_stall, r_out_v && !i_out_ready && r_p4_v, !w_en, "pipeline advanced over a held result")
    `GPP_ASSERT_NOW(a_root_range, r_vld[SQ_END], w_sq[SQRT_N].root[MAG_W-1] || w_sq[SQRT_N].root[MAG_W-2], "root below 2^29")
    `GPP_ASSERT_NOW(a_out_in_frame, o_out_valid, r_out_col < FRAME_WIDTH && r_out_row < FRAME_HEIGHT, "result outside frame")

endmodule

>>> sim/geodetic_point_projector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geodetic_point_projector_tb
// Streams geodetic points through the projector under several rotation and
// zoom settings, with random gaps on input and stalls on output. A scoreboard
// predicts each visible pixel in fixed point and checks the results in order.
// ----------------------------------------------------------------------------
import gpp_pkg::*;

typedef struct {
    logic [9:0]  col;
    logic [9:0]  row;
    logic [19:0] index;
} t_pixel;

class pixel_scoreboard;
    localparam logic [63:0] Q30      = 64'd1 << 30;
    localparam logic [63:0] ECC2     = 64'd7188036;
    localparam logic [63:0] POLAR_K  = Q30 - ECC2;
    localparam logic [63:0] A_METRES = 64'd6378137;

    logic [15:0] rotation;
    logic [31:0] zoom;
    t_pixel      pending_pixels[$];
    int          errors;

    function new();
        rotation = 16'd0;
        zoom     = ZOOM_RESET;
        errors   = 0;
    endfunction

    function automatic logic [63:0] quarter_sine(input logic [63:0] x);
        logic [63:0] u, p, s;
        if (x >= Q30) return Q30;
        u = (x * x) >> 30;
        p = 64'd172272;
        p = 64'd5026995    - ((u * p) >> 30);
        p = 64'd85569306   - ((u * p) >> 30);
        p = 64'd693598668  - ((u * p) >> 30);
        p = 64'd1686629713 - ((u * p) >> 30);
        s = (x * p) >> 30;
        return (s > Q30) ? Q30 : s;
    endfunction

    function automatic logic [63:0] sine_mag(input logic [15:0] ang, output bit neg);
        logic [14:0] r;
        logic [63:0] m;
        r = {1'b0, ang[13:0]};
        if (ang[14]) r = 15'd16384 - r;
        m = quarter_sine(64'(r) << 16);
        neg = ang[15] && (m != 0);
        return m;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bit place(input logic [63:0] mag, input bit neg, input longint half,
                                 input longint lim, output logic [63:0] pos);
        longint centre, scaled, t;
        centre = half <<< 32;
        scaled = longint'(mag * 64'(zoom));
        t = neg ? centre - scaled : centre + scaled;
        pos = 0;
        if (t < 0) return 0;
        pos = 64'(t) >> 32;
        return (longint'(pos) < lim);
    endfunction

    function void write_reg(input logic [7:0] idx, input logic [31:0] data);
        if (idx == REG_ROTATION) rotation = data[15:0];
        else if (idx == REG_ZOOM) zoom = data;
    endfunction

    // predict the pixel for one accepted point, if it is visible
    function void note_point(input logic [15:0] lat, input logic [15:0] lon_in);
        logic [15:0] lon;
        bit nsl, ncl, nsn, ncn, negy, negz;
        logic [63:0] sl, cl, sn, cn, s2, d, root, n, ncos, mx, my, mz, col, rr, row;
        t_pixel px;
        lon = lon_in + rotation;
        sl = sine_mag(lat, nsl);
        cl = sine_mag(lat + 16'd16384, ncl);
        sn = sine_mag(lon, nsn);
        cn = sine_mag(lon + 16'd16384, ncn);
        s2 = (sl * sl) >> 30;
        d = Q30 - ((ECC2 * s2) >> 30);
        root = int_sqrt(d << 30);
        if (root == 0) root = 1;
        n = (A_METRES << 30) / root;
        ncos = (n * cl) >> 30;
        mx = (ncos * cn) >> 30;
        // drop far side
        if ((ncl != ncn) && mx != 0) return;
        my = (ncos * sn) >> 30;
        negy = (ncl != nsn) && my != 0;
        mz = (((n * POLAR_K) >> 30) * sl) >> 30;
        negz = nsl && mz != 0;
        if (!place(my, negy, HALF_W, FRAME_WIDTH, col)) return;
        if (!place(mz, negz, HALF_H, FRAME_HEIGHT, rr)) return;
        row = 64'(FRAME_HEIGHT - 1) - rr;
        px.col   = col[9:0];
        px.row   = row[9:0];
        px.index = 20'(row * 64'(FRAME_WIDTH) + col);
        pending_pixels.push_back(px);
    endfunction

    function void check_result(input logic [9:0] col, input logic [9:0] row,
                               input logic [19:0] index);
        t_pixel px;
        if (pending_pixels.size() == 0) begin
            $error("unexpected pixel col=%0d row=%0d index=%0d", col, row, index);
            errors++;
            return;
        end
        px = pending_pixels.pop_front();
        if (col !== px.col) begin
            $error("pixel_col: expected %0d, got %0d", px.col, col);
            errors++;
        end
        if (row !== px.row) begin
            $error("pixel_row: expected %0d, got %0d", px.row, row);
            errors++;
        end
        if (index !== px.index) begin
            $error("pixel_index: expected %0d, got %0d", px.index, index);
            errors++;
        end
    endfunction
endclass

module geodetic_point_projector_tb;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          DRAIN_CYCLES   = 90;
    localparam logic [7:0]  REG_SPARE      = 8'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [15:0] i_latitude = '0;
    logic [15:0] i_longitude = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b1;
    logic [9:0]  o_pixel_col;
    logic [9:0]  o_pixel_row;
    logic [19:0] o_pixel_index;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    pixel_scoreboard sb = new();
    bit idle_on = 1'b1;
    int stall_left = 0;
    int quiet_cycles = 0;

    always #10 i_clk = ~i_clk;

    geodetic_point_projector i_dut (.*);

    // output stalls in random bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idle_on && i_rst_n && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_reg(i_cfg_index, i_cfg_data);
                quiet_cycles = 0;
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_point(i_latitude, i_longitude);
                quiet_cycles = 0;
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_pixel_col, o_pixel_row, o_pixel_index);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_point(input logic [15:0] lat, input logic [15:0] lon);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_latitude  <= lat;
        i_longitude <= lon;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [7:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_points(input int count);
        int lat;
        repeat (count) begin
            if ($urandom_range(0, 7) == 0) lat = $urandom_range(0, 65535);
            else lat = $urandom_range(0, 32768) - 16384;
            send_point(16'(lat), 16'($urandom_range(0, 65535)));
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: poles, equator, meridian plane, far side, wrapped angles
        send_point(16'd0, 16'd0);
        send_point(16'd16384, 16'd0);
        send_point(-16'sd16384, 16'd0);
        send_point(16'd16383, 16'd100);
        send_point(16'hFFFF, 16'd65535);
        send_point(16'd0, 16'd16384);
        send_point(16'd0, 16'd49152);
        send_point(16'd0, 16'd32768);
        send_point(16'd0, 16'd16385);
        send_point(16'd0, 16'd49151);
        send_point(16'd8192, 16'd8192);
        send_point(-16'sd8192, 16'd57344);
        send_point(16'h7FFF, 16'd1);
        send_point(16'h8000, 16'd2);
        send_point(16'd32768 - 16'd100, 16'd3);
        send_point(16'h5555, 16'hAAAA);
        send_point(16'hAAAA, 16'h5555);
        random_points(280);
        settle();

        write_cfg(REG_ROTATION, 32'd16384);
        write_cfg(REG_SPARE, 32'hFFFF_FFFF);
        send_point(16'd0, 16'd0);
        random_points(150);
        settle();

        // zero zoom puts every visible point at the centre
        write_cfg(REG_ROTATION, 32'h0001_FFFF);
        write_cfg(REG_ZOOM, 32'd0);
        random_points(100);
        settle();

        // maximum zoom: only points near the centre stay on the frame
        write_cfg(REG_ROTATION, 32'd0);
        write_cfg(REG_ZOOM, 32'hFFFF_FFFF);
        send_point(16'd0, 16'd0);
        send_point(16'd0, 16'd1);
        send_point(16'd1, 16'd0);
        send_point(16'd0, 16'd65535);
        random_points(100);
        settle();

        write_cfg(REG_ROTATION, $urandom_range(0, 65535));
        write_cfg(REG_ZOOM, $urandom_range(300000, 600000));
        random_points(250);
        settle();

        // final stretch without gaps or stalls
        write_cfg(REG_ROTATION, 32'd65535);
        write_cfg(REG_ZOOM, ZOOM_RESET);
        idle_on = 1'b0;
        random_points(200);
        settle();

        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/gpp_pkg.sv
rtl/core/gpp_sine.sv
rtl/core/gpp_sqrt_cell.sv
rtl/core/gpp_div_cell.sv
rtl/core/geodetic_point_projector.sv
sim/geodetic_point_projector_tb.sv
